FILE: rtl/rcaw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcaw_pkg;

  // Field widths of the item and result transfers.
  localparam int COORD_W = 16;
  localparam int COLOR_W = 16;
  localparam int WIN_W   = 9;
  localparam int CNT_W   = 14;

  // Working width of the clipping arithmetic: a 16-bit anchor plus a 16-bit
  // size with a carry either way never leaves this range.
  localparam int CALC_W = 20;

  // Default panel geometry.
  localparam int PANEL_SHORT_DEF = 80;
  localparam int PANEL_LONG_DEF  = 160;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int ROT_W  = 2;
  localparam int OFF_W  = 8;

  localparam logic [ROT_W-1:0] ROTATION_RST   = 2'd3;
  localparam logic [OFF_W-1:0] COL_OFFSET_RST = 8'd24;
  localparam logic [OFF_W-1:0] ROW_OFFSET_RST = 8'd0;

  typedef enum logic [1:0] {
    REG_ROTATION   = 2'd0,
    REG_COL_OFFSET = 2'd1,
    REG_ROW_OFFSET = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [ROT_W-1:0] rotation;
    logic [OFF_W-1:0] col_offset;
    logic [OFF_W-1:0] row_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rect_x;
    logic signed [COORD_W-1:0] rect_y;
    logic signed [COORD_W-1:0] rect_w;
    logic signed [COORD_W-1:0] rect_h;
    logic        [COLOR_W-1:0] fill_color;
  } rect_in_t;

  typedef struct packed {
    logic               visible;
    logic [WIN_W-1:0]   col_start;
    logic [WIN_W-1:0]   col_end;
    logic [WIN_W-1:0]   row_start;
    logic [WIN_W-1:0]   row_end;
    logic [CNT_W-1:0]   pixel_count;
    logic [COLOR_W-1:0] pixel_word;
  } rect_out_t;

endpackage

`default_nettype wire

FILE: rtl/rcaw_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module rcaw_regs (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [rcaw_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rcaw_pkg::DATA_W-1:0] pwdata,
  output logic      [rcaw_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  output rcaw_pkg::cfg_t                cfg
);
  import rcaw_pkg::*;

  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation   <= ROTATION_RST;
      cfg.col_offset <= COL_OFFSET_RST;
      cfg.row_offset <= ROW_OFFSET_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ROTATION:   cfg.rotation   <= pwdata[ROT_W-1:0];
        REG_COL_OFFSET: cfg.col_offset <= pwdata[OFF_W-1:0];
        REG_ROW_OFFSET: cfg.row_offset <= pwdata[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROTATION:   prdata = DATA_W'(cfg.rotation);
      REG_COL_OFFSET: prdata = DATA_W'(cfg.col_offset);
      REG_ROW_OFFSET: prdata = DATA_W'(cfg.row_offset);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/rcaw_clip.sv
`timescale 1ns / 1ps
`default_nettype none

module rcaw_clip #(
  parameter int PANEL_SHORT = rcaw_pkg::PANEL_SHORT_DEF,
  parameter int PANEL_LONG  = rcaw_pkg::PANEL_LONG_DEF
) (
  input  wire rcaw_pkg::rect_in_t rect,
  input  wire rcaw_pkg::cfg_t     cfg,
  output rcaw_pkg::rect_out_t     win
);
  import rcaw_pkg::*;

  localparam logic signed [CALC_W-1:0] ONE     = CALC_W'(1);
  localparam logic signed [CALC_W-1:0] SHORT_S = CALC_W'(PANEL_SHORT);
  localparam logic signed [CALC_W-1:0] LONG_S  = CALC_W'(PANEL_LONG);

  logic signed [CALC_W-1:0] x, y, w, h;
  logic signed [CALC_W-1:0] xa, ya, wa, ha, x2, y2;
  logic signed [CALC_W-1:0] xc, yc, x2c, y2c;
  logic signed [CALC_W-1:0] scr_w, scr_h;
  logic        [OFF_W-1:0]  xoff, yoff;
  logic                     vis;
  logic        [WIN_W-1:0]  cw, ch;
  logic        [2*WIN_W-1:0] area;
  logic        [COLOR_W-1:0] rev;

  always_comb begin
    x = CALC_W'(rect.rect_x);
    y = CALC_W'(rect.rect_y);
    w = CALC_W'(rect.rect_w);
    h = CALC_W'(rect.rect_h);

    // Odd rotations are landscape and swap which offset lands on which axis.
    if (cfg.rotation[0]) begin
      scr_w = LONG_S;
      scr_h = SHORT_S;
      xoff  = cfg.row_offset;
      yoff  = cfg.col_offset;
    end else begin
      scr_w = SHORT_S;
      scr_h = LONG_S;
      xoff  = cfg.col_offset;
      yoff  = cfg.row_offset;
    end

    // A negative size grows back from the anchor.
    xa = (w < 0) ? x + w + ONE : x;
    wa = (w < 0) ? -w : w;
    ya = (h < 0) ? y + h + ONE : y;
    ha = (h < 0) ? -h : h;
    x2 = xa + wa - ONE;
    y2 = ya + ha - ONE;

    vis = (w != 0) && (h != 0) && (xa < scr_w) && (ya < scr_h) && (x2 >= 0) && (y2 >= 0);

    xc  = (xa < 0) ? '0 : xa;
    yc  = (ya < 0) ? '0 : ya;
    x2c = (x2 >= scr_w) ? scr_w - ONE : x2;
    y2c = (y2 >= scr_h) ? scr_h - ONE : y2;

    cw   = x2c[WIN_W-1:0] - xc[WIN_W-1:0] + WIN_W'(1);
    ch   = y2c[WIN_W-1:0] - yc[WIN_W-1:0] + WIN_W'(1);
    area = {{WIN_W{1'b0}}, cw} * {{WIN_W{1'b0}}, ch};

    for (int i = 0; i < COLOR_W; i++) begin
      rev[i] = rect.fill_color[COLOR_W-1-i];
    end

    win = '0;
    if (vis) begin
      win.visible     = 1'b1;
      win.col_start   = xc[WIN_W-1:0] + WIN_W'(xoff);
      win.col_end     = x2c[WIN_W-1:0] + WIN_W'(xoff);
      win.row_start   = yc[WIN_W-1:0] + WIN_W'(yoff);
      win.row_end     = y2c[WIN_W-1:0] + WIN_W'(yoff);
      win.pixel_count = area[CNT_W-1:0];
      win.pixel_word  = rev;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rect_clip_address_window.sv
`timescale 1ns / 1ps
`default_nettype none

// Clips one signed rectangle per clock cycle against the screen and returns
// the panel address window, the pixel count and the bit-reversed fill colour.
// A rectangle transfer is taken at every rising edge with start high; busy
// never rises, so a new rectangle may follow in every cycle. Each result is
// carried through the input register and then the result register to the
// window ports, shown there for a single cycle marked by done, in the order
// the rectangles came in. The receiver cannot stall the block and must take
// the result in that cycle. The clipping arithmetic and one small multiply
// sit between the input register and the result register. The rotation and
// offset registers sit on the APB-style port at byte addresses 0, 4 and 8
// and should only be written while no rectangle is in flight.
module rect_clip_address_window #(
  parameter int PANEL_SHORT = rcaw_pkg::PANEL_SHORT_DEF,
  parameter int PANEL_LONG  = rcaw_pkg::PANEL_LONG_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire rcaw_pkg::rect_in_t          rect,
  output logic                             done,
  output rcaw_pkg::rect_out_t              window,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rcaw_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rcaw_pkg::DATA_W-1:0] pwdata,
  output logic      [rcaw_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import rcaw_pkg::*;

  cfg_t      cfg;
  rect_in_t  rect_q;
  logic      rect_vld;
  rect_out_t win_d;

  // The pipeline never holds anything back.
  assign busy = 1'b0;

  rcaw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register: the rectangle is captured as it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_vld <= 1'b0;
    end else begin
      rect_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rect_q <= rect;
    end
  end

  rcaw_clip #(
    .PANEL_SHORT (PANEL_SHORT),
    .PANEL_LONG  (PANEL_LONG)
  ) u_clip (
    .rect (rect_q),
    .cfg  (cfg),
    .win  (win_d)
  );

  // Result register: done marks a one-cycle transfer of the window.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rect_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rect_vld) begin
      window <= win_d;
    end
  end

`ifndef SYNTHESIS
  // Every result belongs to an earlier rectangle transfer, carried through the input and result registers.
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a matching rectangle transfer");

  // A hidden rectangle carries an all-zero window.
  a_hidden_is_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !window.visible) |-> (window.col_start == '0 && window.col_end == '0 &&
      window.row_start == '0 && window.row_end == '0 &&
      window.pixel_count == '0 && window.pixel_word == '0))
    else $error("hidden rectangle with non-zero window fields");

  // Nothing is delivered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe straight after reset");
`endif

endmodule

`default_nettype wire
